// ===== design/pga_pkg.sv =====
// Shared widths, register map and stage payload types for the gravity pipeline.
package pga_pkg;

  localparam int POS_W    = 32;               // Q16.16 position
  localparam int DIFF_W   = POS_W + 1;        // exact coordinate difference
  localparam int MAG_W    = POS_W;            // |difference| is below 2^32
  localparam int MASS_W   = 32;
  localparam int GRAV_W   = 32;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int R2_W     = 66;               // even width for the root digit pairs
  localparam int ROOT_W   = R2_W / 2;
  localparam int RREM_W   = ROOT_W + 2;       // root partial remainder
  localparam int HALF_W   = R2_W / 2;         // r2 split for the cube product
  localparam int GM_W     = GRAV_W + MASS_W;
  localparam int GMH_W    = GM_W / 2;
  localparam int NUM_W    = GM_W + MAG_W;     // G*m*|d|
  localparam int DEN_W    = 98;               // r2 * floor(sqrt(r2))
  localparam int QUO_W    = 48;
  localparam int OUT_W    = 48;
  localparam int NUM_SH   = 40;               // scale of the numerator
  localparam int LIM_SH   = QUO_W - NUM_SH;   // overflow test: num >= den << 8
  localparam int LIM_W    = DEN_W + LIM_SH;
  localparam int REM_W    = DEN_W + QUO_W;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;
  localparam int IDX_W    = ADDR_W - 2;

  localparam logic [IDX_W-1:0]  REG_GRAVITY = IDX_W'(0);
  localparam logic [GRAV_W-1:0] GRAV_RESET  = GRAV_W'(65536);

  localparam logic [OUT_W-1:0] POS_CAP = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_CAP = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic             neg_x;
    logic             neg_y;
    logic             near;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [QUO_W-1:0] q_x;
    logic [QUO_W-1:0] q_y;
    logic [DEN_W-1:0] den;
    logic             sat_x;
    logic             sat_y;
    logic             neg_x;
    logic             neg_y;
    logic             near;
  } div_t;

endpackage

// ===== design/pga_if.sv =====
// Stream interfaces for body-pair input and acceleration output.
interface pga_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [pga_pkg::POS_W-1:0] self_x;
  logic signed [pga_pkg::POS_W-1:0] self_y;
  logic signed [pga_pkg::POS_W-1:0] other_x;
  logic signed [pga_pkg::POS_W-1:0] other_y;
  logic [pga_pkg::MASS_W-1:0]       other_mass;
  modport source (output valid, self_x, self_y, other_x, other_y, other_mass, input ready);
  modport sink   (input valid, self_x, self_y, other_x, other_y, other_mass, output ready);
endinterface

interface pga_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [pga_pkg::OUT_W-1:0] accel_x;
  logic signed [pga_pkg::OUT_W-1:0] accel_y;
  logic                             too_close;
  logic                             saturated;
  modport source (output valid, accel_x, accel_y, too_close, saturated, input ready);
  modport sink   (input valid, accel_x, accel_y, too_close, saturated, output ready);
endinterface

// ===== design/pga_front.sv =====
// Front stages: differences, squares, G*m and numerator products.
module pga_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [pga_pkg::POS_W-1:0]   self_x_i,
  input  logic [pga_pkg::POS_W-1:0]   self_y_i,
  input  logic [pga_pkg::POS_W-1:0]   other_x_i,
  input  logic [pga_pkg::POS_W-1:0]   other_y_i,
  input  logic [pga_pkg::MASS_W-1:0]  mass_i,
  input  logic [pga_pkg::GRAV_W-1:0]  gravity_i,
  output logic                        valid_o,
  output logic [pga_pkg::R2_W-1:0]    r2_o,
  output pga_pkg::side_t              side_o
);
  import pga_pkg::*;

  logic [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0] dxa, dya;
  logic [R2_W-1:0]   r2_sum;

  logic [3:0]        v_q;
  logic [MAG_W-1:0]  ax0_q, ay0_q, ax1_q, ay1_q;
  logic [1:0]        neg0_q, neg1_q, neg2_q;
  logic [MASS_W-1:0] mass0_q;
  logic [SQ_W-1:0]   sqx1_q, sqy1_q;
  logic [GM_W-1:0]   gm1_q;
  logic [R2_W-1:0]   r22_q, r23_q;
  logic              near2_q;
  logic [GMH_W+MAG_W-1:0] pxl2_q, pxh2_q, pyl2_q, pyh2_q;
  side_t             side3_q;

  assign dx  = {other_x_i[POS_W-1], other_x_i} - {self_x_i[POS_W-1], self_x_i};
  assign dy  = {other_y_i[POS_W-1], other_y_i} - {self_y_i[POS_W-1], self_y_i};
  assign dxa = dx[DIFF_W-1] ? -dx : dx;
  assign dya = dy[DIFF_W-1] ? -dy : dy;
  assign r2_sum = R2_W'(sqx1_q) + R2_W'(sqy1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax0_q   <= dxa[MAG_W-1:0];
      ay0_q   <= dya[MAG_W-1:0];
      neg0_q  <= {dy[DIFF_W-1], dx[DIFF_W-1]};
      mass0_q <= mass_i;
      // squares and G*m
      sqx1_q  <= ax0_q * ax0_q;
      sqy1_q  <= ay0_q * ay0_q;
      gm1_q   <= gravity_i * mass0_q;
      ax1_q   <= ax0_q;
      ay1_q   <= ay0_q;
      neg1_q  <= neg0_q;
      // r2 and numerator partial products
      r22_q   <= r2_sum;
      near2_q <= r2_sum <= (R2_W'(1) << (2 * (POS_W / 2)));
      pxl2_q  <= gm1_q[GMH_W-1:0] * ax1_q;
      pxh2_q  <= gm1_q[GM_W-1:GMH_W] * ax1_q;
      pyl2_q  <= gm1_q[GMH_W-1:0] * ay1_q;
      pyh2_q  <= gm1_q[GM_W-1:GMH_W] * ay1_q;
      neg2_q  <= neg1_q;
      // numerators
      r23_q         <= r22_q;
      side3_q.num_x <= NUM_W'({pxh2_q, {GMH_W{1'b0}}}) + NUM_W'(pxl2_q);
      side3_q.num_y <= NUM_W'({pyh2_q, {GMH_W{1'b0}}}) + NUM_W'(pyl2_q);
      side3_q.neg_x <= neg2_q[0];
      side3_q.neg_y <= neg2_q[1];
      side3_q.near  <= near2_q;
    end
  end

  assign valid_o = v_q[3];
  assign r2_o    = r23_q;
  assign side_o  = side3_q;
endmodule

// ===== design/pga_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module pga_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [pga_pkg::R2_W-1:0]   r2_i,
  input  pga_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [pga_pkg::R2_W-1:0]   r2_o,
  output logic [pga_pkg::ROOT_W-1:0] root_o,
  output pga_pkg::side_t             side_o
);
  import pga_pkg::*;

  logic              v_q    [ROOT_W];
  logic [R2_W-1:0]   r2_q   [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RREM_W-1:0] rem_q  [ROOT_W];
  side_t             side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int P = 2 * (ROOT_W - 1 - k);
    logic              v_in;
    logic [R2_W-1:0]   r2_in;
    logic [ROOT_W-1:0] root_in;
    logic [RREM_W-1:0] rem_in;
    side_t             side_in;
    logic [RREM_W+1:0] cat, trial, diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign r2_in   = r2_i;
      assign root_in = '0;
      assign rem_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign r2_in   = r2_q[k-1];
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign cat   = {rem_in, r2_in[P+1:P]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = cat >= trial;
    assign diff  = cat - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r2_q[k]   <= r2_in;
        side_q[k] <= side_in;
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
        rem_q[k]  <= ge ? diff[RREM_W-1:0] : cat[RREM_W-1:0];
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign r2_o    = r2_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];
endmodule

// ===== design/pga_div.sv =====
// Two-lane restoring divider, one quotient bit per stage.
module pga_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pga_pkg::div_t  data_i,
  output logic           valid_o,
  output pga_pkg::div_t  data_o
);
  import pga_pkg::*;

  logic v_q [QUO_W];
  div_t d_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;
    logic             v_in;
    div_t             d_in;
    div_t             d_nx;
    logic [REM_W-1:0] dsh;
    logic             ge_x, ge_y;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign d_in = data_i;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign d_in = d_q[k-1];
    end

    assign dsh  = REM_W'(d_in.den) << B;
    assign ge_x = d_in.rem_x >= dsh;
    assign ge_y = d_in.rem_y >= dsh;

    always_comb begin
      d_nx = d_in;
      if (ge_x) begin
        d_nx.rem_x  = d_in.rem_x - dsh;
        d_nx.q_x[B] = 1'b1;
      end
      if (ge_y) begin
        d_nx.rem_y  = d_in.rem_y - dsh;
        d_nx.q_y[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k] <= d_nx;
      end
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign data_o  = d_q[QUO_W-1];
endmodule

// ===== design/pairwise_gravity_acceleration.sv =====
// Top level: pairwise 2D gravitational acceleration pipeline with APB register.
//
//  channel | dir | handshake        | payload
//  in_s    | in  | valid/ready      | self_x, self_y, other_x, other_y, other_mass
//  out_m   | out | valid/ready      | accel_x, accel_y, too_close, saturated
//  apb     | in  | psel/penable     | gravity_constant at address 0
//
// Accepts one body pair per cycle unless the output stalls; the pipe has 4 front stages, 33 root
// stages (one bit each), 3 cube/overflow stages, 48 divider stages (one quotient
// bit each) and 1 output register.
// Reset clears only valid bits and the register (G = 1.0).
// When the output register holds an untaken result the whole pipe freezes;
// nothing is dropped or repeated, and bubbles still flow out.
module pairwise_gravity_acceleration (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pga_in_if.sink                      in_s,
  pga_out_if.source                   out_m,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pga_pkg::ADDR_W-1:0]  paddr,
  input  logic [pga_pkg::DATA_W-1:0]  pwdata,
  output logic [pga_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import pga_pkg::*;

  // config register
  logic [GRAV_W-1:0] gravity_q;
  logic              reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[ADDR_W-1:2] == REG_GRAVITY;
  assign prdata  = reg_hit ? DATA_W'(gravity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= GRAV_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      gravity_q <= pwdata[GRAV_W-1:0];
    end
  end

  // global advance: move whenever the output slot is free or being drained
  logic out_v_q;
  logic en;

  assign en         = !out_v_q || out_m.ready;
  assign in_s.ready = en;

  // front stages
  logic            fr_v;
  logic [R2_W-1:0] fr_r2;
  side_t           fr_side;

  pga_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_s.valid),
    .self_x_i  (in_s.self_x),
    .self_y_i  (in_s.self_y),
    .other_x_i (in_s.other_x),
    .other_y_i (in_s.other_y),
    .mass_i    (in_s.other_mass),
    .gravity_i (gravity_q),
    .valid_o   (fr_v),
    .r2_o      (fr_r2),
    .side_o    (fr_side)
  );

  // floor(sqrt(r2))
  logic              sq_v;
  logic [R2_W-1:0]   sq_r2;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  pga_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .r2_i    (fr_r2),
    .side_i  (fr_side),
    .valid_o (sq_v),
    .r2_o    (sq_r2),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // cube: r2 * root in two halves, then sum, then overflow test
  logic [2:0]                v_q;
  logic [HALF_W+ROOT_W-1:0]  plo1_q, phi1_q;
  side_t                     side1_q, side2_q;
  logic [DEN_W-1:0]          den2_q;
  logic [DEN_W:0]            den_sum;
  logic [LIM_W-1:0]          lim;
  div_t                      div3_q;

  assign den_sum = (DEN_W+1)'({phi1_q, {HALF_W{1'b0}}}) + (DEN_W+1)'(plo1_q);
  assign lim     = {den2_q, {LIM_SH{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[1:0], sq_v};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      plo1_q  <= sq_r2[HALF_W-1:0] * sq_root;
      phi1_q  <= sq_r2[R2_W-1:HALF_W] * sq_root;
      side1_q <= sq_side;
      den2_q  <= den_sum[DEN_W-1:0];
      side2_q <= side1_q;
      // quotient would need more than 48 bits: clip without dividing
      div3_q.sat_x <= LIM_W'(side2_q.num_x) >= lim;
      div3_q.sat_y <= LIM_W'(side2_q.num_y) >= lim;
      div3_q.rem_x <= REM_W'({side2_q.num_x, {NUM_SH{1'b0}}});
      div3_q.rem_y <= REM_W'({side2_q.num_y, {NUM_SH{1'b0}}});
      div3_q.q_x   <= '0;
      div3_q.q_y   <= '0;
      div3_q.den   <= den2_q;
      div3_q.neg_x <= side2_q.neg_x;
      div3_q.neg_y <= side2_q.neg_y;
      div3_q.near  <= side2_q.near;
    end
  end

  // quotients
  logic dv_v;
  div_t dv_d;

  pga_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_q[2]),
    .data_i  (div3_q),
    .valid_o (dv_v),
    .data_o  (dv_d)
  );

  // clip to the signed range, apply sign; returns {clipped, value}
  function automatic logic [OUT_W:0] clip_lane(logic [QUO_W-1:0] q, logic neg, logic sat);
    logic [OUT_W-1:0] cap;
    logic [OUT_W-1:0] mag;
    logic             clip;
    cap  = neg ? NEG_CAP : POS_CAP;
    clip = sat || (OUT_W'(q) > cap);
    mag  = clip ? cap : OUT_W'(q);
    return {clip, neg ? -mag : mag};
  endfunction

  logic [OUT_W:0]   lane_x, lane_y;
  logic [OUT_W-1:0] ax_q, ay_q;
  logic             near_q, sat_q;

  assign lane_x = clip_lane(dv_d.q_x, dv_d.neg_x, dv_d.sat_x);
  assign lane_y = clip_lane(dv_d.q_y, dv_d.neg_y, dv_d.sat_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      near_q <= dv_d.near;
      // too close: zero acceleration, no clip flag
      ax_q   <= dv_d.near ? '0 : lane_x[OUT_W-1:0];
      ay_q   <= dv_d.near ? '0 : lane_y[OUT_W-1:0];
      sat_q  <= !dv_d.near && (lane_x[OUT_W] || lane_y[OUT_W]);
    end
  end

  assign out_m.valid     = out_v_q;
  assign out_m.accel_x   = ax_q;
  assign out_m.accel_y   = ay_q;
  assign out_m.too_close = near_q;
  assign out_m.saturated = sat_q;

`ifndef SYNTHESIS
  a_near_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid && out_m.too_close |->
      out_m.accel_x == '0 && out_m.accel_y == '0 && !out_m.saturated)
    else $error("too-close result not zeroed");

  a_sat_at_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid && out_m.saturated |->
      ax_q == POS_CAP || ax_q == NEG_CAP || ay_q == POS_CAP || ay_q == NEG_CAP)
    else $error("saturated flag without a clipped component");

  a_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_m.ready |=> out_v_q && $stable(ax_q) && $stable(ay_q))
    else $error("pipeline advanced during output stall");
`endif
endmodule

// ===== test/pga_checker.sv =====
// Scoreboard for the gravity pipeline: predicts accelerations and compares each output transfer.
`timescale 1ns / 1ps
module pga_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  pga_in_if                          in_mon,
  pga_out_if                         out_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pga_pkg::ADDR_W-1:0] paddr,
  input  logic [pga_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  output int                         fail_count_o,
  output int                         pending_o
);
  import pga_pkg::*;

  typedef logic [159:0] wide_t;

  typedef struct packed {
    logic [OUT_W-1:0] accel_x;
    logic [OUT_W-1:0] accel_y;
    logic             too_close;
    logic             saturated;
  } accel_t;

  logic [GRAV_W-1:0] grav_q;
  accel_t            accel_queue[$];

  // One axis: floor(gm*mag*2^40 / den), clipped, then signed.
  function automatic logic [OUT_W-1:0] axis_accel(wide_t gm, wide_t mag, logic neg,
                                                  wide_t den, inout logic sat);
    wide_t num;
    wide_t q;
    wide_t cap;
    num = (gm * mag) << NUM_SH;
    cap = neg ? wide_t'(NEG_CAP) : wide_t'(POS_CAP);
    if (num >= (den << QUO_W)) begin
      q   = cap;
      sat = 1'b1;
    end else begin
      q = num / den;
      if (q > cap) begin
        q   = cap;
        sat = 1'b1;
      end
    end
    return neg ? OUT_W'(-q) : OUT_W'(q);
  endfunction

  function automatic accel_t predict_accel(logic [31:0] sx, logic [31:0] sy,
                                           logic [31:0] ox, logic [31:0] oy,
                                           logic [31:0] mass, logic [31:0] g);
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    wide_t  mx, my, r2, root, cand, den, gm;
    logic   sat;
    accel_t res;
    dx = $signed({ox[31], ox}) - $signed({sx[31], sx});
    dy = $signed({oy[31], oy}) - $signed({sy[31], sy});
    mx = dx[32] ? wide_t'(-dx) & 160'h1_FFFF_FFFF : wide_t'(dx) & 160'h1_FFFF_FFFF;
    my = dy[32] ? wide_t'(-dy) & 160'h1_FFFF_FFFF : wide_t'(dy) & 160'h1_FFFF_FFFF;
    r2 = mx * mx + my * my;
    res = '0;
    if (r2 <= (wide_t'(1) << 32)) begin
      res.too_close = 1'b1;
      return res;
    end
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (wide_t'(1) << b);
      if (cand * cand <= r2) root = cand;
    end
    den = r2 * root;
    gm  = wide_t'(g) * wide_t'(mass);
    sat = 1'b0;
    res.accel_x   = axis_accel(gm, mx, dx[32], den, sat);
    res.accel_y   = axis_accel(gm, my, dy[32], den, sat);
    res.saturated = sat;
    return res;
  endfunction

  assign pending_o = accel_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q       <= GRAV_RESET;
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_GRAVITY, 2'b00})
        grav_q <= pwdata;
      if (out_mon.valid && out_mon.ready) begin
        accel_t got;
        accel_t exp_r;
        got = '{out_mon.accel_x, out_mon.accel_y, out_mon.too_close, out_mon.saturated};
        if (accel_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = accel_queue.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected ax=%h ay=%h tc=%b sat=%b got ax=%h ay=%h tc=%b sat=%b",
                     $realtime, exp_r.accel_x, exp_r.accel_y, exp_r.too_close, exp_r.saturated,
                     got.accel_x, got.accel_y, got.too_close, got.saturated);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        accel_queue.push_back(predict_accel(in_mon.self_x, in_mon.self_y, in_mon.other_x,
                                            in_mon.other_y, in_mon.other_mass, grav_q));
    end
  end
endmodule

// ===== test/testbench.sv =====
// Top of the gravity pipeline test: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps
module testbench;
  import pga_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 120;
  localparam int RAND_PER_PHASE = 190;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  int  fail_count;
  int  pending;
  int  cycle_cnt = 0;
  int  sent_cnt = 0;
  bit  steady = 1'b0;   // no idling on either side while set
  bit  held = 1'b0;
  int  hold_left = 0;

  pga_in_if  in_bus();
  pga_out_if out_bus();

  pairwise_gravity_acceleration dut (
    .clk_i, .rst_ni, .in_s(in_bus), .out_m(out_bus),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pga_checker u_checker (
    .clk_i, .rst_ni, .in_mon(in_bus), .out_mon(out_bus),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random backpressure, plus one long hold-off once the pipe is busy
  // so that it fills up and stalls the input side.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && sent_cnt >= 300) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= steady ? 1'b1 : ($urandom_range(99) >= 24);
      end
    end
  end

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // One body-pair transfer, with random idle cycles in front of it unless steady is set.
  task automatic send_pair(logic [31:0] sx, logic [31:0] sy, logic [31:0] ox,
                           logic [31:0] oy, logic [31:0] mass);
    while (!steady && $urandom_range(99) < 24) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.self_x <= sx; in_bus.self_y <= sy;
    in_bus.other_x <= ox; in_bus.other_y <= oy;
    in_bus.other_mass <= mass;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // Sender stops and waits for every expected result before a register write.
  task automatic drain_pipe();
    in_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Random pairs: mostly close bodies (too-close, saturation, big accelerations),
  // the rest spread over the full coordinate range.
  task automatic send_random(int count);
    logic [31:0] sx, sy, ox, oy, m, off_x, off_y;
    int kind;
    for (int i = 0; i < count; i++) begin
      sx = $urandom(); sy = $urandom();
      kind = $urandom_range(3);
      off_x = $urandom() >>> $urandom_range(31);
      off_y = $urandom() >>> $urandom_range(31);
      if ($urandom_range(1)) off_x = -off_x;
      if ($urandom_range(1)) off_y = -off_y;
      case (kind)
        0: begin ox = $urandom(); oy = $urandom(); end
        1: begin ox = sx + ($urandom() & 32'h1FFFF) - 32'h10000;
                 oy = sy + ($urandom() & 32'h1FFFF) - 32'h10000; end
        default: begin ox = sx + off_x; oy = sy + off_y; end
      endcase
      if ($urandom_range(5) == 0) oy = sy;   // axis-aligned pair
      m = $urandom_range(1) ? $urandom() : ($urandom() >> $urandom_range(31));
      send_pair(sx, sy, ox, oy, m);
    end
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.self_x = '0; in_bus.self_y = '0;
    in_bus.other_x = '0; in_bus.other_y = '0;
    in_bus.other_mass = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed pairs at the reset value of G.
    send_pair(32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);            // same spot
    send_pair(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'd10);          // exactly one apart
    send_pair(32'h0, 32'h0, 32'h0001_0001, 32'h0, 32'd10);          // just beyond one
    send_pair(32'h0, 32'h0, 32'hFFFF_0000, 32'h0, 32'd10);          // one apart, negative
    send_pair(32'h0, 32'h0, 32'h0000_B505, 32'h0000_B505, 32'd7);   // diagonal near one
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_pair(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'd1);   // y difference zero
    send_pair(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'd1);   // x difference zero
    send_pair(32'h0, 32'h0, 32'h0001_0001, 32'h0, 32'hFFFF_FFFF);   // positive clip
    send_pair(32'h0, 32'h0, 32'hFFFE_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF); // negative clip
    send_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, 32'h8765_4321, 32'h0);   // no mass
    send_pair(32'h0, 32'h0, 32'h0010_0000, 32'h0020_0000, 32'd1000);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555);
    send_random(RAND_PER_PHASE);

    // Register phases: G at zero, at its maximum, random, at the smallest step,
    // and back to 1.0 with a write to an unused address that must be ignored.
    drain_pipe();
    reg_write({REG_GRAVITY, 2'b00}, 32'h0);
    send_random(RAND_PER_PHASE);

    drain_pipe();
    reg_write({REG_GRAVITY, 2'b00}, 32'hFFFF_FFFF);
    send_pair(32'h0, 32'h0, 32'h0001_0001, 32'h0, 32'hFFFF_FFFF);
    steady = 1'b1;
    send_random(RAND_PER_PHASE);
    steady = 1'b0;

    drain_pipe();
    reg_write({REG_GRAVITY, 2'b00}, $urandom());
    send_random(RAND_PER_PHASE);

    drain_pipe();
    reg_write({REG_GRAVITY, 2'b00}, 32'h1);
    send_random(RAND_PER_PHASE);

    drain_pipe();
    reg_write({REG_GRAVITY, 2'b00}, GRAV_RESET);
    reg_write(ADDR_W'(4), 32'hDEAD_BEEF);
    send_random(RAND_PER_PHASE);

    drain_pipe();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
